### rtl/core/srfd_pkg.sv
// srfd_pkg: shared types, constants and functions for the sensor response frame decoder
// used by srfd_front, srfd_queue, srfd_back and the top level; no dependencies

package srfd_pkg;

    // read mode register codes
    localparam logic [1:0] MODE_TEMP = 2'd0;
    localparam logic [1:0] MODE_HUM  = 2'd1;
    localparam logic [1:0] MODE_BOTH = 2'd2;

    // crc-16/modbus constants
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // byte positions inside a frame
    localparam logic [3:0] POS_WORD1_HI      = 4'd2;
    localparam logic [3:0] POS_WORD1_LO      = 4'd3;
    localparam logic [3:0] POS_WORD2_HI      = 4'd4;
    localparam logic [3:0] POS_WORD2_LO      = 4'd5;
    localparam logic [3:0] POS_CRC_LO_SINGLE = 4'd4;
    localparam logic [3:0] POS_CRC_LO_BOTH   = 4'd6;

    // one complete frame, handed from the front to the back
    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] calc_crc;
        logic [15:0] rx_crc;
        logic [15:0] first_word;
        logic [15:0] second_word;
    } frame_rec_t;

    // one decoded result
    typedef struct packed {
        logic signed [15:0] temperature_tenths;
        logic               temperature_valid;
        logic [15:0]        humidity_tenths;
        logic               humidity_valid;
        logic               crc_ok;
    } result_t;

    // handshake between a queue and its producer or consumer
    typedef struct packed {
        logic push;
        logic full;
    } queue_wr_t;

    typedef struct packed {
        logic pop;
        logic empty;
    } queue_rd_t;

    // reflected crc update, one byte in eight shift steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // sign-magnitude word to two's complement
    function automatic logic signed [15:0] sign_mag_to_twos(input logic [15:0] w);
        logic [15:0] r;
        if (w[15])
            r = 16'd0 - {1'b0, w[14:0]};
        else
            r = w;
        return signed'(r);
    endfunction

endpackage

### rtl/core/srfd_front.sv
// srfd_front: takes response bytes, runs the crc and byte position, captures data words
// depends on srfd_pkg; pushes one frame record per completed frame into the queue

module srfd_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [1:0]            read_mode,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            data_byte,
    input  logic                  frame_start,
    output srfd_pkg::queue_wr_t   qwr,
    input  logic                  q_full,
    output srfd_pkg::frame_rec_t  rec
);

    logic [15:0] crc_reg, crc_next;
    logic [3:0]  pos_reg, pos_next;
    logic [15:0] first_word_reg, first_word_next;
    logic [15:0] second_word_reg, second_word_next;
    logic [7:0]  rx_low_reg, rx_low_next;

    logic        accept;
    logic        both;
    logic [3:0]  crc_lo_pos;
    logic [3:0]  pos_eff;
    logic [15:0] crc_eff;
    logic        is_last;

    assign in_ready   = !q_full;
    assign accept     = in_valid && in_ready;
    assign both       = read_mode[1];
    assign crc_lo_pos = both ? srfd_pkg::POS_CRC_LO_BOTH : srfd_pkg::POS_CRC_LO_SINGLE;
    assign pos_eff    = frame_start ? 4'd0 : pos_reg;
    assign crc_eff    = frame_start ? srfd_pkg::CRC_INIT : crc_reg;
    assign is_last    = pos_eff > crc_lo_pos;

    // classify the byte and update frame state
    always_comb
    begin
        crc_next         = crc_reg;
        pos_next         = pos_reg;
        first_word_next  = first_word_reg;
        second_word_next = second_word_reg;
        rx_low_next      = rx_low_reg;
        if (accept)
        begin
            if (pos_eff < crc_lo_pos)
            begin
                crc_next = srfd_pkg::crc_byte(crc_eff, data_byte);
                pos_next = pos_eff + 4'd1;
                case (pos_eff)
                    srfd_pkg::POS_WORD1_HI: first_word_next  = {data_byte, first_word_reg[7:0]};
                    srfd_pkg::POS_WORD1_LO: first_word_next  = {first_word_reg[15:8], data_byte};
                    srfd_pkg::POS_WORD2_HI: second_word_next = {data_byte, second_word_reg[7:0]};
                    srfd_pkg::POS_WORD2_LO: second_word_next = {second_word_reg[15:8], data_byte};
                    default: ;
                endcase
            end
            else if (pos_eff == crc_lo_pos)
            begin
                crc_next    = crc_eff;
                rx_low_next = data_byte;
                pos_next    = pos_eff + 4'd1;
            end
            else
            begin
                crc_next = srfd_pkg::CRC_INIT;
                pos_next = 4'd0;
            end
        end
    end

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg         <= srfd_pkg::CRC_INIT;
            pos_reg         <= 4'd0;
            first_word_reg  <= 16'd0;
            second_word_reg <= 16'd0;
            rx_low_reg      <= 8'd0;
        end
        else
        begin
            crc_reg         <= crc_next;
            pos_reg         <= pos_next;
            first_word_reg  <= first_word_next;
            second_word_reg <= second_word_next;
            rx_low_reg      <= rx_low_next;
        end
    end

    // completed frame record
    assign qwr.push        = accept && is_last;
    assign qwr.full        = q_full;
    assign rec.mode        = read_mode;
    assign rec.calc_crc    = crc_eff;
    assign rec.rx_crc      = {data_byte, rx_low_reg};
    assign rec.first_word  = first_word_reg;
    assign rec.second_word = second_word_reg;

endmodule

### rtl/core/srfd_queue.sv
// srfd_queue: small register queue of frame records between front and back
// depends on srfd_pkg for the handshake structs

module srfd_queue
#(
    parameter int WIDTH = 66,
    parameter int DEPTH = 2
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  srfd_pkg::queue_wr_t wr,
    input  logic [WIDTH-1:0]    wr_data,
    output logic                full,
    input  srfd_pkg::queue_rd_t rd,
    output logic                empty,
    output logic [WIDTH-1:0]    rd_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_IDX = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = count_reg == FULL_CNT;
    assign empty   = count_reg == '0;
    assign do_push = wr.push && !full;
    assign do_pop  = rd.pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // pointer and count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == LAST_IDX) ? '0 : wr_ptr_reg + PW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == LAST_IDX) ? '0 : rd_ptr_reg + PW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("queue count beyond depth");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !wr.push)
        else $error("push into full queue");

    a_count_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> count_reg == $past(count_reg) + CW'(1))
        else $error("queue count did not grow on push");

endmodule

### rtl/core/srfd_back.sv
// srfd_back: decodes queued frame records into results and holds the output register
// depends on srfd_pkg

module srfd_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  srfd_pkg::frame_rec_t  rec,
    input  logic                  q_empty,
    output srfd_pkg::queue_rd_t   qrd,
    output logic                  out_valid,
    input  logic                  out_ready,
    output srfd_pkg::result_t     res
);

    logic                  out_valid_reg, out_valid_next;
    srfd_pkg::result_t     res_reg;
    srfd_pkg::result_t     res_next;
    logic                  load;
    logic                  both, has_h, has_t, ok;
    logic [15:0]           tw;

    assign load = !q_empty && (!out_valid_reg || out_ready);

    // decode the record at the queue head
    always_comb
    begin
        both  = rec.mode[1];
        has_h = both || (rec.mode == srfd_pkg::MODE_HUM);
        has_t = both || (rec.mode == srfd_pkg::MODE_TEMP);
        ok    = rec.rx_crc == rec.calc_crc;
        tw    = both ? rec.second_word : rec.first_word;
        res_next.crc_ok             = ok;
        res_next.humidity_valid     = has_h && ok;
        res_next.humidity_tenths    = has_h ? rec.first_word : 16'd0;
        res_next.temperature_valid  = has_t && ok;
        res_next.temperature_tenths = has_t ? srfd_pkg::sign_mag_to_twos(tw) : 16'sd0;
    end

    // output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_next;
    end

    assign qrd.pop   = load;
    assign qrd.empty = q_empty;
    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    // checks
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        qrd.pop |-> !q_empty)
        else $error("pop from empty queue");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> out_valid_reg)
        else $error("loaded result not presented");

    a_flags_need_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !res_reg.crc_ok |-> !res_reg.humidity_valid && !res_reg.temperature_valid)
        else $error("valid flag set on bad crc");

endmodule

### rtl/core/sensor_response_frame_decoder_unit.sv
// sensor_response_frame_decoder_unit: top level of the sensor response frame decoder
// depends on srfd_pkg, srfd_front, srfd_queue and srfd_back

// Takes one response byte per cycle on the s_ side, s_tuser marking the first byte
// of a frame. Every byte but the last two goes through a CRC-16/MODBUS update in the
// front stage; the frame length (6 or 8 bytes) follows read_mode, written on the cfg
// channel (0 temperature, 1 humidity, 2 or 3 both). At the last byte a frame record
// enters a QUEUE_DEPTH-entry queue and the back stage turns it into one result on the
// m_ side; m_tvalid rises once the record has passed the queue and the output register,
// when that register is free. Sustained rate is one byte per clock while s_tready is
// high, set by the combinational unrolled byte CRC in the front stage; s_tready drops
// only while the queue is full, which happens only when the m_ side is held off.

module sensor_response_frame_decoder_unit
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,      // read_mode
    // byte input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,       // [7:0] data_byte
    input  logic        s_tuser,       // [0] frame_start
    // result output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata        // [0] crc_ok, [1] humidity_valid, [17:2] humidity_tenths,
                                       // [18] temperature_valid, [34:19] temperature_tenths,
                                       // [39:35] zero
);

    logic [1:0]            read_mode_reg;
    srfd_pkg::queue_wr_t   qwr;
    srfd_pkg::queue_rd_t   qrd;
    srfd_pkg::frame_rec_t  rec_in, rec_out;
    srfd_pkg::result_t     res;
    logic                  q_full, q_empty;

    // mode register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            read_mode_reg <= srfd_pkg::MODE_BOTH;
        else if (cfg_valid && cfg_ready)
            read_mode_reg <= cfg_data;
    end

    // front: byte classification and crc
    srfd_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .read_mode   (read_mode_reg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .data_byte   (s_tdata),
        .frame_start (s_tuser),
        .qwr         (qwr),
        .q_full      (q_full),
        .rec         (rec_in)
    );

    // frame record queue
    srfd_queue #(
        .WIDTH ($bits(srfd_pkg::frame_rec_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (qwr),
        .wr_data (rec_in),
        .full    (q_full),
        .rd      (qrd),
        .empty   (q_empty),
        .rd_data (rec_out)
    );

    // back: decode and output register
    srfd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec       (rec_out),
        .q_empty   (q_empty),
        .qrd       (qrd),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .res       (res)
    );

    assign m_tdata = {5'd0, res};

endmodule

### dv/tb_top.sv
// tb_top: self-checking testbench for sensor_response_frame_decoder_unit
// depends on srfd_pkg and the decoder rtl; drives response bytes and checks every decoded result
// against a cycle-free frame decoder model kept here or the plan's expected values, under random back-pressure

module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    // spare mode code, decodes as both values
    localparam logic [1:0]  MODE_SPARE    = 2'd3;
    localparam logic [15:0] MODBUS_SEED   = 16'hFFFF;
    localparam logic [15:0] MODBUS_POLY_R = 16'hA001;
    localparam logic [15:0] FLIP_NONE     = 16'h0000;
    localparam logic [15:0] FLIP_BOTH     = 16'h0101;
    localparam logic [7:0]  HDR_FUNC      = 8'h03;
    localparam logic [7:0]  HDR_COUNT     = 8'h04;
    localparam int          BYTE_TARGET   = 1600;

    typedef enum logic [1:0] {SK_FRAME, SK_BYTES, SK_MODE} step_kind_t;

    // one row of the directed plan
    typedef struct packed {
        step_kind_t         kind;
        logic [3:0]         arg;          // mode code or raw byte count
        logic               with_start;
        logic [15:0]        word_a;
        logic [15:0]        word_b;
        logic               bad_crc;
        logic               typed;
        srfd_pkg::result_t  want;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data = srfd_pkg::MODE_BOTH;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;       // [7:0] data_byte
    logic        s_tuser = 1'b0;        // [0] frame_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;               // [0] crc_ok, [1] humidity_valid, [17:2] humidity_tenths,
                                        // [18] temperature_valid, [34:19] temperature_tenths

    // frame decoder model state
    logic [1:0]  fm_mode = srfd_pkg::MODE_BOTH;
    logic [15:0] fm_crc = MODBUS_SEED;
    logic [3:0]  fm_pos = 4'd0;
    logic [15:0] fm_word1 = 16'h0000;
    logic [15:0] fm_word2 = 16'h0000;
    logic [7:0]  fm_crc_lo = 8'h00;

    srfd_pkg::result_t pending_readings [$];
    int          bytes_sent = 0;
    int          failures = 0;
    bit          hold_req = 1'b0;

    // directed plan: extremes, every mode, bad crc, negative zero, missing start,
    // restart mid-frame and a mode change mid-frame
    plan_row_t plan [18] = '{
        '{SK_FRAME, 4'd0, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b1,
          '{16'sh0000, 1'b1, 16'h0000, 1'b1, 1'b1}},
        '{SK_FRAME, 4'd0, 1'b1, 16'hFFFF, 16'h7FFF, 1'b0, 1'b1,
          '{16'sh7FFF, 1'b1, 16'hFFFF, 1'b1, 1'b1}},
        '{SK_FRAME, 4'd0, 1'b1, 16'h0000, 16'hFFFF, 1'b0, 1'b1,
          '{16'sh8001, 1'b1, 16'h0000, 1'b1, 1'b1}},
        '{SK_FRAME, 4'd0, 1'b1, 16'h0123, 16'h8000, 1'b0, 1'b1,
          '{16'sh0000, 1'b1, 16'h0123, 1'b1, 1'b1}},
        '{SK_FRAME, 4'd0, 1'b1, 16'h1234, 16'h80FF, 1'b1, 1'b1,
          '{16'shFF01, 1'b0, 16'h1234, 1'b0, 1'b0}},
        '{SK_FRAME, 4'd0, 1'b0, 16'h0271, 16'h00C8, 1'b0, 1'b0, '0},
        '{SK_MODE, {2'b00, srfd_pkg::MODE_TEMP}, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, '0},
        '{SK_FRAME, 4'd0, 1'b1, 16'h8001, 16'h0000, 1'b0, 1'b1,
          '{16'shFFFF, 1'b1, 16'h0000, 1'b0, 1'b1}},
        '{SK_FRAME, 4'd0, 1'b1, 16'h7FFF, 16'h0000, 1'b1, 1'b1,
          '{16'sh7FFF, 1'b0, 16'h0000, 1'b0, 1'b0}},
        '{SK_MODE, {2'b00, srfd_pkg::MODE_HUM}, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, '0},
        '{SK_FRAME, 4'd0, 1'b1, 16'hFFFF, 16'h0000, 1'b0, 1'b1,
          '{16'sh0000, 1'b0, 16'hFFFF, 1'b1, 1'b1}},
        '{SK_BYTES, 4'd3, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0, '0},
        '{SK_FRAME, 4'd0, 1'b1, 16'h0640, 16'h0000, 1'b0, 1'b0, '0},
        '{SK_MODE, {2'b00, MODE_SPARE}, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, '0},
        '{SK_FRAME, 4'd0, 1'b1, 16'hAAAA, 16'h5555, 1'b0, 1'b0, '0},
        '{SK_BYTES, 4'd6, 1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0, '0},
        '{SK_MODE, {2'b00, srfd_pkg::MODE_TEMP}, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, '0},
        '{SK_BYTES, 4'd1, 1'b0, 16'h0000, 16'h0000, 1'b0, 1'b0, '0}
    };

    sensor_response_frame_decoder_unit i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // 12 ns clock
    initial
    begin
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // overall run limit
    initial
    begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // stretch of the run with no idling on either side
    function automatic bit quiet_stretch();
        return bytes_sent >= 1000 && bytes_sent < 1250;
    endfunction

    // reflected crc-16 update over one byte
    function automatic logic [15:0] modbus_update(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] c;
        c = acc ^ {8'h00, b};
        repeat (8)
        begin
            c = (c >> 1) ^ ({16{c[0]}} & MODBUS_POLY_R);
        end
        return c;
    endfunction

    // one byte through the frame decoder model; returns 1 when a reading comes out
    function automatic bit decode_byte(input logic [7:0] b, input logic st,
                                       output srfd_pkg::result_t r);
        logic        both;
        int          len;
        logic [15:0] rx;
        logic [15:0] tw;
        logic        ok;
        r = '0;
        both = fm_mode[1];
        len = both ? 8 : 6;
        if (st)
        begin
            fm_crc = MODBUS_SEED;
            fm_pos = 4'd0;
        end
        // payload bytes feed the crc
        if (int'(fm_pos) < len - 2)
        begin
            fm_crc = modbus_update(fm_crc, b);
            case (fm_pos)
                srfd_pkg::POS_WORD1_HI: fm_word1[15:8] = b;
                srfd_pkg::POS_WORD1_LO: fm_word1[7:0]  = b;
                srfd_pkg::POS_WORD2_HI: fm_word2[15:8] = b;
                srfd_pkg::POS_WORD2_LO: fm_word2[7:0]  = b;
                default: ;
            endcase
            fm_pos = fm_pos + 4'd1;
            return 1'b0;
        end
        if (int'(fm_pos) == len - 2)
        begin
            fm_crc_lo = b;
            fm_pos = fm_pos + 4'd1;
            return 1'b0;
        end
        // last byte, at or beyond the end of the current length
        rx = {b, fm_crc_lo};
        ok = (rx == fm_crc);
        r.crc_ok = ok;
        if (both || fm_mode == srfd_pkg::MODE_HUM)
        begin
            r.humidity_tenths = fm_word1;
            r.humidity_valid = ok;
        end
        if (both || fm_mode == srfd_pkg::MODE_TEMP)
        begin
            tw = both ? fm_word2 : fm_word1;
            if (tw[15])
                tw = ~{1'b0, tw[14:0]} + 16'd1;
            r.temperature_tenths = tw;
            r.temperature_valid = ok;
        end
        fm_crc = MODBUS_SEED;
        fm_pos = 4'd0;
        return 1'b1;
    endfunction

    // word biased towards the sign-magnitude corners
    function automatic logic [15:0] pick_word();
        if ($urandom_range(0, 99) < 25)
        begin
            case ($urandom_range(0, 5))
                0: return 16'h0000;
                1: return 16'hFFFF;
                2: return 16'h7FFF;
                3: return 16'h8000;
                4: return 16'h8001;
                default: return 16'h0001;
            endcase
        end
        return 16'($urandom);
    endfunction

    // offer one byte, each cycle idle with the same small chance outside the quiet stretch
    task automatic push_byte(input logic [7:0] b, input logic st);
        if (!quiet_stretch())
        begin
            while ($urandom_range(0, 99) < 29)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= st;
        do @(posedge clk); while (!s_tready);
        bytes_sent++;
    endtask

    // send a byte and queue whatever reading it should produce
    task automatic take_byte(input logic [7:0] b, input logic st, input bit typed,
                             input srfd_pkg::result_t want);
        srfd_pkg::result_t r;
        bit                has;
        push_byte(b, st);
        has = decode_byte(b, st, r);
        if (has)
            pending_readings.push_back(typed ? want : r);
    endtask

    // whole response frame for the current mode, crc optionally corrupted
    task automatic send_frame(input logic [15:0] wa, input logic [15:0] wb, input logic st,
                              input logic [15:0] crc_flip, input logic [7:0] h0,
                              input logic [7:0] h1, input bit typed,
                              input srfd_pkg::result_t want);
        logic [7:0]  fb [8];
        int          len;
        logic [15:0] c;
        len = fm_mode[1] ? 8 : 6;
        fb[0] = h0;
        fb[1] = h1;
        fb[2] = wa[15:8];
        fb[3] = wa[7:0];
        fb[4] = wb[15:8];
        fb[5] = wb[7:0];
        c = MODBUS_SEED;
        for (int i = 0; i < len - 2; i++)
        begin
            c = modbus_update(c, fb[i]);
        end
        c = c ^ crc_flip;
        fb[len - 2] = c[7:0];
        fb[len - 1] = c[15:8];
        for (int i = 0; i < len; i++)
        begin
            take_byte(fb[i], st && (i == 0), typed, want);
        end
    endtask

    // let every reading drain, then wait out the pipeline
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_readings.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // read_mode write while the decoder is idle
    task automatic load_mode(input logic [1:0] md);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= md;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        fm_mode = md;
    endtask

    // result side ready, with one long hold-off to back the decoder up
    initial
    begin : ready_driver
        int hold_left;
        bit held;
        hold_left = 0;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && hold_req)
            begin
                held = 1'b1;
                hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (quiet_stretch())
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= 29);
        end
    end

    // compare each result transaction with the oldest pending reading
    always @(posedge clk)
    begin : reading_check
        srfd_pkg::result_t got;
        srfd_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[34:0];
            if (pending_readings.size() == 0)
            begin
                $error("unexpected result transaction: %h", m_tdata);
                failures++;
            end
            else
            begin
                want = pending_readings.pop_front();
                if (got.crc_ok !== want.crc_ok)
                begin
                    $error("crc_ok: expected %0d, got %0d", want.crc_ok, got.crc_ok);
                    failures++;
                end
                if (got.humidity_valid !== want.humidity_valid)
                begin
                    $error("humidity_valid: expected %0d, got %0d",
                           want.humidity_valid, got.humidity_valid);
                    failures++;
                end
                if (got.humidity_tenths !== want.humidity_tenths)
                begin
                    $error("humidity_tenths: expected %0d, got %0d",
                           want.humidity_tenths, got.humidity_tenths);
                    failures++;
                end
                if (got.temperature_valid !== want.temperature_valid)
                begin
                    $error("temperature_valid: expected %0d, got %0d",
                           want.temperature_valid, got.temperature_valid);
                    failures++;
                end
                if (got.temperature_tenths !== want.temperature_tenths)
                begin
                    $error("temperature_tenths: expected %0d, got %0d",
                           want.temperature_tenths, got.temperature_tenths);
                    failures++;
                end
                if (m_tdata[39:35] !== 5'd0)
                begin
                    $error("pad bits: expected %0d, got %0d", 5'd0, m_tdata[39:35]);
                    failures++;
                end
            end
        end
    end

    // reset, directed plan, random phases, drain and verdict
    initial
    begin : stimulus
        int         phase;
        int         nframes;
        int         pick;
        int         wait_cycles;
        logic [1:0] md;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed plan
        for (int i = 0; i < $size(plan); i++)
        begin
            case (plan[i].kind)
                SK_MODE:
                    load_mode(plan[i].arg[1:0]);
                SK_BYTES:
                    for (int n = 0; n < int'(plan[i].arg); n++)
                        take_byte(8'($urandom), plan[i].with_start && (n == 0), 1'b0, '0);
                default:
                    send_frame(plan[i].word_a, plan[i].word_b, plan[i].with_start,
                               plan[i].bad_crc ? FLIP_BOTH : FLIP_NONE, HDR_FUNC, HDR_COUNT,
                               plan[i].typed, plan[i].want);
            endcase
        end

        // random phases, each under one mode
        phase = 0;
        while (bytes_sent < BYTE_TARGET)
        begin
            md = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3));
            load_mode(md);
            // long hold-off starts with a fresh phase so the sender keeps offering
            if (!hold_req && bytes_sent >= 700)
                hold_req = 1'b1;
            nframes = $urandom_range(15, 35);
            for (int f = 0; f < nframes && bytes_sent < BYTE_TARGET; f++)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    send_frame(pick_word(), pick_word(), ($urandom_range(0, 7) != 0),
                               FLIP_NONE, 8'($urandom), 8'($urandom), 1'b0, '0);
                else if (pick < 90)
                    send_frame(pick_word(), pick_word(), 1'b1,
                               16'($urandom_range(1, 16'hFFFF)), 8'($urandom), 8'($urandom),
                               1'b0, '0);
                else
                    for (int n = $urandom_range(1, 9); n > 0; n--)
                        take_byte(8'($urandom), 1'($urandom), 1'b0, '0);
            end
            phase++;
        end

        // drain with a bound, then a short tail
        s_tvalid <= 1'b0;
        wait_cycles = 0;
        while (pending_readings.size() != 0 && wait_cycles < 5000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (10) @(posedge clk);
        if (pending_readings.size() != 0)
        begin
            $error("readings never delivered: %0d", pending_readings.size());
            failures++;
        end
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### sensor_response_frame_decoder_unit.f
rtl/core/srfd_pkg.sv
rtl/core/srfd_front.sv
rtl/core/srfd_queue.sv
rtl/core/srfd_back.sv
rtl/core/sensor_response_frame_decoder_unit.sv
dv/tb_top.sv
